// File: rtl/rtcs_pkg.sv
// Shared types and constants for the seconds counter with slew correction.
package rtcs_pkg;

    localparam int TIME_W          = 32;
    localparam int ERR_W           = 8;
    localparam int S_TDATA_W       = 32;
    localparam int S_TUSER_W       = 2;
    localparam int M_TDATA_W       = 40;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [TIME_W-1:0] VALID_FLOOR_RESET = 32'd978307200;
    // Signed window of +-127 seen as an unsigned 32-bit difference
    localparam logic [TIME_W-1:0] SLEW_LIMIT_POS    = 32'd127;
    localparam logic [TIME_W-1:0] SLEW_LIMIT_NEG    = 32'hFFFF_FF81;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_SET_TIME  = 2'd1,
        OP_SET_ALARM = 2'd2,
        OP_CANCEL    = 2'd3
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [TIME_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// File: rtl/rtcs_front.sv
// Front stage: accept input transactions, decode the opcode, hand commands to the queue.
module rtcs_front
    import rtcs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] op
    input  queue_status_t        q_status,
    output logic                 push,
    output cmd_t                 push_cmd
);

    logic front_valid_reg, front_valid_next;
    cmd_t front_cmd_reg, front_cmd_next;
    logic accept;

    // Take a new transaction when the stage is empty or drains this cycle
    assign push     = front_valid_reg && !q_status.full;
    assign s_tready = !front_valid_reg || !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign push_cmd = front_cmd_reg;

    // Decode and hold the command
    always_comb begin
        front_valid_next = front_valid_reg;
        front_cmd_next   = front_cmd_reg;
        if (accept) begin
            front_valid_next     = 1'b1;
            front_cmd_next.op    = op_t'(s_tuser);
            front_cmd_next.value = s_tdata[TIME_W-1:0];
        end else if (push) begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        front_cmd_reg <= front_cmd_next;
    end

endmodule

// File: rtl/rtcs_queue.sv
// Short command queue between the front and back stages.
module rtcs_queue
    import rtcs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic          pop,
    output cmd_t          pop_cmd,
    output queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_cmd      = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/rtcs_back.sv
// Back stage: run one command against the clock state and register the result.
module rtcs_back
    import rtcs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TIME_W-1:0]    cfg_data,
    input  queue_status_t        q_status,
    input  cmd_t                 pop_cmd,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [TIME_W-1:0] floor_reg, floor_next;
    logic [TIME_W-1:0] count_reg, count_next;
    logic [ERR_W-1:0]  error_reg, error_next;
    logic [ERR_W-1:0]  budget_reg, budget_next;
    logic [TIME_W-1:0] last_set_reg, last_set_next;
    logic [TIME_W-1:0] alarm_time_reg, alarm_time_next;
    logic              armed_reg, armed_next;
    logic              pending_reg, pending_next;

    logic              out_valid_reg, out_valid_next;
    logic [TIME_W-1:0] out_time_reg, out_time_next;
    logic              out_tvalid_bit_reg, out_tvalid_bit_next;
    logic              out_alarm_reg, out_alarm_next;
    logic              out_slew_reg, out_slew_next;

    logic              slew_active;
    logic [ERR_W-1:0]  err_mag;
    logic              slew_adjust;
    logic [TIME_W-1:0] tick_count;
    logic [TIME_W-1:0] set_diff;
    logic              set_in_window;
    logic [ERR_W-1:0]  set_mag;

    assign cfg_ready = 1'b1;
    assign pop       = !q_status.empty && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_TDATA_W - TIME_W - 3){1'b0}},
                        out_slew_reg, out_alarm_reg, out_tvalid_bit_reg, out_time_reg};

    // Hold the counter or skip a second while the budget allows it
    assign slew_active = (error_reg != '0) && (budget_reg != '0);
    assign err_mag     = error_reg[ERR_W-1] ? (ERR_W'(0) - error_reg) : error_reg;
    assign slew_adjust = slew_active && ({1'b0, budget_reg} < {err_mag, 1'b0});

    always_comb begin
        tick_count = count_reg + 32'd1;
        if (slew_adjust) begin
            tick_count = error_reg[ERR_W-1] ? count_reg + 32'd2 : count_reg;
        end
    end

    // Classify the set-time difference: slew inside the window, jump outside
    assign set_diff      = count_reg - pop_cmd.value;
    assign set_in_window = (set_diff <= SLEW_LIMIT_POS) || (set_diff >= SLEW_LIMIT_NEG);
    assign set_mag       = (set_diff <= SLEW_LIMIT_POS) ? set_diff[ERR_W-1:0]
                                                        : ERR_W'(32'd0 - set_diff);

    // Execute the popped command
    always_comb begin
        floor_next      = cfg_valid ? cfg_data : floor_reg;
        count_next      = count_reg;
        error_next      = error_reg;
        budget_next     = budget_reg;
        last_set_next   = last_set_reg;
        alarm_time_next = alarm_time_reg;
        armed_next      = armed_reg;
        pending_next    = pending_reg;
        if (pop) begin
            case (pop_cmd.op)
                OP_TICK: begin
                    count_next = tick_count;
                    if (slew_active) begin
                        budget_next = budget_reg - 1'b1;
                        if (slew_adjust) begin
                            error_next = error_reg[ERR_W-1] ? error_reg + 1'b1
                                                            : error_reg - 1'b1;
                        end
                    end
                    if (armed_reg && (tick_count == alarm_time_reg)) begin
                        pending_next = 1'b1;
                    end
                end
                OP_SET_TIME: begin
                    if (set_in_window) begin
                        error_next  = set_diff[ERR_W-1:0];
                        budget_next = {set_mag[ERR_W-2:0], 1'b0};
                    end else begin
                        count_next = pop_cmd.value;
                    end
                    last_set_next = pop_cmd.value;
                end
                OP_SET_ALARM: begin
                    alarm_time_next = count_reg + pop_cmd.value;
                    armed_next      = 1'b1;
                end
                OP_CANCEL: begin
                    armed_next   = 1'b0;
                    pending_next = 1'b0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Build the result from the state after the command
    always_comb begin
        out_valid_next      = out_valid_reg;
        out_time_next       = out_time_reg;
        out_tvalid_bit_next = out_tvalid_bit_reg;
        out_alarm_next      = out_alarm_reg;
        out_slew_next       = out_slew_reg;
        if (pop) begin
            out_valid_next      = 1'b1;
            out_time_next       = count_next;
            out_tvalid_bit_next = (count_next >= floor_reg) &&
                                  !((last_set_next != '0) && (count_next < last_set_next));
            out_alarm_next      = pending_next;
            out_slew_next       = (error_next != '0) && (budget_next != '0);
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg      <= VALID_FLOOR_RESET;
            count_reg      <= '0;
            error_reg      <= '0;
            budget_reg     <= '0;
            last_set_reg   <= '0;
            alarm_time_reg <= '0;
            armed_reg      <= 1'b0;
            pending_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            floor_reg      <= floor_next;
            count_reg      <= count_next;
            error_reg      <= error_next;
            budget_reg     <= budget_next;
            last_set_reg   <= last_set_next;
            alarm_time_reg <= alarm_time_next;
            armed_reg      <= armed_next;
            pending_reg    <= pending_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_time_reg       <= out_time_next;
        out_tvalid_bit_reg <= out_tvalid_bit_next;
        out_alarm_reg      <= out_alarm_next;
        out_slew_reg       <= out_slew_next;
    end

endmodule

// File: rtl/rtc_seconds_counter_with_slew.sv
// Top level of the seconds counter with slew correction and relative alarm.
//
// Usage:
//   s_ channel carries commands: s_tuser is the opcode (tick, set time, set alarm
//   offset, cancel alarm) and s_tdata the 32-bit value. Every command gives exactly
//   one result transaction on the m_ channel: counter, time-valid, alarm and
//   slewing flags. The cfg_ channel writes the valid-time floor; write it only
//   while no command is in flight.
// Data path:
//   A command is registered in the front stage, passes a short queue and is
//   executed by the back stage, which registers the result. One command per
//   cycle is sustained while m_tready stays high.
// Reset:
//   aresetn low clears the counter, slew state, alarm and queue, and loads the
//   floor with its default. All channels are idle after reset.
// Back-pressure:
//   While m_tready is low the result register holds; the queue and the front
//   register keep taking commands until both are full, then s_tready drops.
module rtc_seconds_counter_with_slew
    import rtcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [S_TUSER_W-1:0] s_tuser,   // [1:0] op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] current_time, [32] time_valid, [33] alarm_flag, [34] slewing, [39:35] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TIME_W-1:0]    cfg_data
);

    queue_status_t q_status;
    logic          push;
    logic          pop;
    cmd_t          push_cmd;
    cmd_t          pop_cmd;

    rtcs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    rtcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    rtcs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Never pop an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !q_status.empty)
        else $error("pop from empty command queue");

    // Never push into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !q_status.full)
        else $error("push into full command queue");

    // An accepted transaction is pushed to the queue on the next cycle unless the queue is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (push || q_status.full))
        else $error("accepted transaction not forwarded");

    // A popped command always yields a result on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn) pop |=> m_tvalid)
        else $error("executed command produced no result");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the seconds counter with slew correction and relative alarm.
module tb;
    import rtcs_pkg::*;

    // Idle margin after the last result has come back, in cycles
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_HOLD    = 200;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [TIME_W-1:0] seconds;
        logic              valid;
        logic              alarm;
        logic              slewing;
    } clock_status_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TIME_W-1:0]    cfg_data  = '0;

    // Predicted block state
    logic [TIME_W-1:0]       clk_count;
    logic signed [ERR_W-1:0] skew_err;
    logic [ERR_W-1:0]        skew_budget;
    logic [TIME_W-1:0]       last_set;
    logic [TIME_W-1:0]       alarm_at;
    logic                    alarm_armed;
    logic                    alarm_hit;
    logic [TIME_W-1:0]       floor_q;

    clock_status_t status_due[$];

    int err_count    = 0;
    int cmds_sent    = 0;
    int src_max_gap  = 8;
    int sink_max_stall = 8;
    int hold_cycles  = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rtc_seconds_counter_with_slew u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic void note_fail(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endfunction

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            note_fail($sformatf("%s expected 0x%08h, got 0x%08h", fname, want, got));
        end
    endfunction

    function automatic void clear_clock_state();
        clk_count   = '0;
        skew_err    = '0;
        skew_budget = '0;
        last_set    = '0;
        alarm_at    = '0;
        alarm_armed = 1'b0;
        alarm_hit   = 1'b0;
        floor_q     = VALID_FLOOR_RESET;
    endfunction

    // Apply one command to the predicted state and queue the status it produces
    function automatic void advance_clock(op_t op, logic [TIME_W-1:0] value);
        clock_status_t st;
        logic [TIME_W-1:0] step;
        logic [TIME_W-1:0] diff;
        logic [TIME_W-1:0] mag32;
        logic [TIME_W-1:0] twice;
        int e;
        int b;
        int mag;
        int q;
        case (op)
            OP_TICK: begin
                step = 32'd1;
                e = skew_err;
                b = skew_budget;
                if (e != 0 && b != 0) begin
                    mag = (e < 0) ? -e : e;
                    q = b / mag;
                    // Hold while ahead, double-step while behind, at a ratio under two
                    if (e > 0) begin
                        if (q < 2) begin
                            step = 32'd0;
                            e--;
                        end
                    end else if (q < 2) begin
                        step = 32'd2;
                        e++;
                    end
                    skew_err = e[ERR_W-1:0];
                    skew_budget = skew_budget - 8'd1;
                end
                clk_count = clk_count + step;
                if (alarm_armed && clk_count == alarm_at) begin
                    alarm_hit = 1'b1;
                end
            end
            OP_SET_TIME: begin
                diff = clk_count - value;
                if (diff <= SLEW_LIMIT_POS || diff >= SLEW_LIMIT_NEG) begin
                    mag32 = (diff <= SLEW_LIMIT_POS) ? diff : -diff;
                    twice = mag32 << 1;
                    skew_err = diff[ERR_W-1:0];
                    skew_budget = twice[ERR_W-1:0];
                end else begin
                    clk_count = value;
                end
                last_set = value;
            end
            OP_SET_ALARM: begin
                alarm_at = clk_count + value;
                alarm_armed = 1'b1;
            end
            default: begin
                alarm_armed = 1'b0;
                alarm_hit = 1'b0;
            end
        endcase
        st.seconds = clk_count;
        st.valid = (clk_count >= floor_q) && !(last_set != '0 && clk_count < last_set);
        st.alarm = alarm_hit;
        st.slewing = (skew_err != '0) && (skew_budget != '0);
        status_due.push_back(st);
    endfunction

    // Offer one command after a random gap; leave tvalid high for a back-to-back follower
    task automatic send_cmd(input op_t op, input logic [TIME_W-1:0] value);
        int gap;
        gap = $urandom_range(src_max_gap, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_clock(op, value);
        cmds_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_cmd(OP_TICK, $urandom);
    endtask

    // Stop offering and wait until every predicted status has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_floor(input logic [TIME_W-1:0] f);
        cfg_valid <= 1'b1;
        cfg_data  <= f;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        floor_q = f;
    endtask

    // Extremes, each opcode, slew windows, alarm re-arm and cancel
    task automatic test_directed();
        send_cmd(OP_TICK, 32'd0);
        send_cmd(OP_SET_ALARM, 32'd2);
        send_ticks(2);
        send_cmd(OP_SET_ALARM, 32'hFFFF_FFFF);
        send_cmd(OP_TICK, 32'hFFFF_FFFF);
        send_cmd(OP_CANCEL, 32'hFFFF_FFFF);
        send_cmd(OP_SET_TIME, 32'hFFFF_FFFF);
        send_cmd(OP_TICK, 32'd0);
        send_cmd(OP_SET_TIME, clk_count + 32'd128);
        send_cmd(OP_SET_TIME, clk_count - 32'd128);
        send_cmd(OP_SET_TIME, clk_count + 32'd127);
        send_cmd(OP_SET_ALARM, 32'd1);
        send_ticks(3);
        send_cmd(OP_SET_TIME, clk_count - 32'd127);
        send_cmd(OP_SET_ALARM, 32'd0);
        send_ticks(2);
        send_cmd(OP_SET_TIME, 32'd0);
        send_cmd(OP_SET_TIME, VALID_FLOOR_RESET - 32'd1);
        send_cmd(OP_TICK, 32'd0);
        send_cmd(OP_CANCEL, 32'd0);
        send_cmd(OP_TICK, 32'd0);
    endtask

    // Floor register at both extremes and just ahead of the counter
    task automatic test_floor_register();
        settle();
        write_floor(32'd0);
        send_cmd(OP_SET_TIME, 32'd1000);
        send_ticks(2);
        settle();
        write_floor(32'hFFFF_FFFF);
        send_cmd(OP_SET_TIME, 32'hFFFF_FFFD);
        send_ticks(4);
        settle();
        write_floor(clk_count + 32'd3);
        send_ticks(6);
        settle();
        write_floor(VALID_FLOOR_RESET);
    endtask

    // Hold off results long enough to fill the block, then pause until drained
    task automatic test_backpressure();
        settle();
        src_max_gap = 0;
        hold_cycles = LONG_HOLD;
        repeat (40) begin
            if ($urandom_range(3, 0) == 0) begin
                send_cmd(OP_SET_TIME, clk_count + 32'($urandom_range(20, 0)) - 32'd10);
            end else begin
                send_cmd(OP_TICK, $urandom);
            end
        end
        settle();
        src_max_gap = 8;
    endtask

    // Well-formed command sequences with random content, plus noise
    task automatic test_random_traffic(input int n_cmds);
        int target;
        int mag;
        int d;
        logic [TIME_W-1:0] v;
        target = cmds_sent + n_cmds;
        while (cmds_sent < target) begin
            case ($urandom_range(9, 0))
                0, 1, 2: send_ticks($urandom_range(20, 1));
                3: begin
                    // Small set-time correction, then work it off
                    mag = ($urandom_range(3, 0) == 0) ? $urandom_range(127, 0)
                                                      : $urandom_range(10, 0);
                    d = $urandom_range(1, 0) ? -mag : mag;
                    send_cmd(OP_SET_TIME, clk_count - d);
                    send_ticks(2 * mag + $urandom_range(3, 0));
                end
                4: begin
                    send_cmd(OP_SET_ALARM, $urandom_range(6, 0));
                    send_ticks($urandom_range(8, 1));
                    if ($urandom_range(1, 0)) begin
                        send_cmd(OP_CANCEL, $urandom);
                    end
                end
                5: begin
                    v = $urandom_range(1, 0) ? 32'($urandom)
                                             : floor_q + 32'($urandom_range(16, 0)) - 32'd8;
                    send_cmd(OP_SET_TIME, v);
                    send_ticks($urandom_range(10, 1));
                end
                6: begin
                    // Window edges: +-127 slews, +-128 jumps
                    d = $urandom_range(1, 0) ? 127 : 128;
                    if ($urandom_range(1, 0)) d = -d;
                    send_cmd(OP_SET_TIME, clk_count - d);
                    send_ticks($urandom_range(4, 1));
                end
                7: send_cmd(OP_CANCEL, $urandom);
                8: send_cmd(op_t'($urandom_range(3, 0)), $urandom);
                default: begin
                    case ($urandom_range(2, 0))
                        0: v = 32'd0;
                        1: v = 32'hFFFF_FFF0 + 32'($urandom_range(15, 0));
                        default: v = last_set + 32'($urandom_range(6, 0)) - 32'd3;
                    endcase
                    send_cmd(OP_SET_TIME, v);
                    send_ticks($urandom_range(20, 1));
                end
            endcase
        end
    endtask

    // Accept results after a random stall, or after a long hold when one is requested
    initial begin : result_sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else begin
                stall = $urandom_range(sink_max_stall, 0);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : status_check
        clock_status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (status_due.size() == 0) begin
                note_fail($sformatf("result with none expected: 0x%010h", m_tdata));
            end else begin
                want = status_due.pop_front();
                check_field("current_time", want.seconds, m_tdata[31:0]);
                check_field("time_valid", 32'(want.valid), 32'(m_tdata[32]));
                check_field("alarm_flag", 32'(want.alarm), 32'(m_tdata[33]));
                check_field("slewing", 32'(want.slewing), 32'(m_tdata[34]));
            end
        end
    end

    initial begin
        #5_000_000;
        $display("rtc_seconds_counter_with_slew test failed");
        $finish;
    end

    initial begin
        logic [TIME_W-1:0] phase_floor[4];
        clear_clock_state();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_floor_register();
        test_backpressure();

        // Random phases over several floor settings and idle patterns
        for (int p = 0; p < 4; p++) begin
            settle();
            phase_floor = '{32'd0, 32'hFFFF_FFFF, clk_count + 32'd50, VALID_FLOOR_RESET};
            write_floor(phase_floor[p]);
            src_max_gap    = (p == 1 || p == 3) ? 0 : 8;
            sink_max_stall = (p == 1 || p == 2) ? 0 : 8;
            test_random_traffic(295);
        end

        settle();
        if (status_due.size() != 0) begin
            note_fail($sformatf("%0d results never arrived", status_due.size()));
        end
        if (err_count == 0) begin
            $display("rtc_seconds_counter_with_slew test passed");
        end else begin
            $display("rtc_seconds_counter_with_slew test failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/rtcs_pkg.sv
rtl/rtcs_front.sv
rtl/rtcs_queue.sv
rtl/rtcs_back.sv
rtl/rtc_seconds_counter_with_slew.sv
tb/sv/tb.sv
